// ----- design/crt_pkg.sv -----
package crt_pkg;

	// Index and vector geometry
	localparam int CRT_INDEX_DEPTH = 32;
	localparam int VEC_DIM = 8;
	localparam int COMP_W = 16;
	localparam int ID_W = 32;
	localparam int NORM_W = 35;
	localparam int DIST_W = 32;
	localparam int CFG_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int RANK_W = 6;
	localparam int RANK_MAX = 63;

	// Q2.30 distance constants
	localparam logic [DIST_W-1:0] DIST_ONE = 32'h4000_0000;
	localparam logic [DIST_W-1:0] DIST_TWO = 32'h8000_0000;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_ENTRY_COUNT = 6'd0;
	localparam logic [CFG_W-1:0] RST_CUTOFF_FIRST = 6'd1;
	localparam logic [CFG_W-1:0] RST_CUTOFF_SECOND = 6'd5;
	localparam logic [CFG_W-1:0] RST_CUTOFF_THIRD = 6'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRY_COUNT   = 2'd0,
		CFG_CUTOFF_FIRST  = 2'd1,
		CFG_CUTOFF_SECOND = 2'd2,
		CFG_CUTOFF_THIRD  = 2'd3
	} crt_cfg_idx_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} crt_req_kind_t;

	typedef struct packed {
		logic               req_type;
		logic [4:0]         slot;
		logic [ID_W-1:0]    doc_id;
		logic signed [15:0] comp0;
		logic signed [15:0] comp1;
		logic signed [15:0] comp2;
		logic signed [15:0] comp3;
		logic signed [15:0] comp4;
		logic signed [15:0] comp5;
		logic signed [15:0] comp6;
		logic signed [15:0] comp7;
	} crt_req_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              hit_first;
		logic              hit_second;
		logic              hit_third;
	} crt_rsp_t;

	typedef logic [VEC_DIM-1:0][COMP_W-1:0] crt_vec_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		crt_vec_t          vec;
		logic [NORM_W-1:0] norm;
		logic [DIST_W-1:0] distance;
	} crt_entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} crt_cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_NORM = 3'd1,
		ST_DIST = 3'd2,
		ST_RANK = 3'd3,
		ST_DONE = 3'd4
	} crt_state_t;

	typedef enum logic [2:0] {
		DS_IDLE = 3'd0,
		DS_MUL  = 3'd1,
		DS_ROOT = 3'd2,
		DS_DIV  = 3'd3,
		DS_DONE = 3'd4
	} crt_dstate_t;

	function automatic crt_vec_t crt_req_vec(input crt_req_t r);
		crt_vec_t v;
		v[0] = r.comp0;
		v[1] = r.comp1;
		v[2] = r.comp2;
		v[3] = r.comp3;
		v[4] = r.comp4;
		v[5] = r.comp5;
		v[6] = r.comp6;
		v[7] = r.comp7;
		return v;
	endfunction

endpackage

// ----- design/crt_cell.sv -----
module crt_cell import crt_pkg::*; (
	input  logic          clk,
	input  crt_cell_ctl_t ctl,
	input  crt_entry_t    shift_in,
	input  crt_entry_t    load_in,
	output crt_entry_t    entry
);

	crt_entry_t entry_q;

	// Take a new entry on a load, else take the neighbour's on a shift
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_in;
		end else if (ctl.shift) begin
			entry_q <= shift_in;
		end
	end

	assign entry = entry_q;

endmodule

// ----- design/crt_dist.sv -----
module crt_dist import crt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  crt_vec_t          qvec,
	input  logic [NORM_W-1:0] qnorm,
	input  crt_vec_t          evec,
	input  logic [NORM_W-1:0] enorm,
	output logic              done,
	output logic [DIST_W-1:0] distance
);

	localparam int PROD_W = 2 * NORM_W;
	localparam int REM_W = 38;
	localparam int DOT_W = 36;
	localparam int QUO_W = 31;
	localparam logic [5:0] MUL_LAST = 6'(NORM_W - 1);
	localparam logic [5:0] ROOT_LAST = 6'(NORM_W - 1);
	localparam logic [5:0] DIV_LAST = 6'(QUO_W - 1);

	crt_dstate_t state_q, state_d;
	logic [5:0] cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [NORM_W-1:0] mb_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [REM_W-1:0] rem_q;
	logic [NORM_W-1:0] root_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIST_W-1:0] dist_q;

	logic signed [31:0] prod;
	logic [REM_W-1:0] rem_cat, trial, div_ext, div_rem;
	logic root_ge, div_ge;
	logic [DOT_W-1:0] mag;
	logic [QUO_W-1:0] quo_new;
	logic [DIST_W-1:0] q_ext, dist_new;
	logic zero_norm;

	always_comb begin
		prod = $signed(qvec[cnt_q[2:0]]) * $signed(evec[cnt_q[2:0]]);
		zero_norm = (qnorm == '0) || (enorm == '0);
		// one root digit: bring down two bits of the product
		rem_cat = {rem_q[REM_W-3:0], acc_q[PROD_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		root_ge = rem_cat >= trial;
		// one quotient bit of the restoring divide
		div_ext = {3'b000, root_q};
		div_ge = rem_q >= div_ext;
		div_rem = div_ge ? (rem_q - div_ext) : rem_q;
		quo_new = {quo_q[QUO_W-2:0], div_ge};
		mag = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
		q_ext = {1'b0, quo_new};
		if (dot_q[DOT_W-1]) begin
			dist_new = (q_ext > DIST_ONE) ? DIST_TWO : (DIST_ONE + q_ext);
		end else begin
			dist_new = (q_ext > DIST_ONE) ? '0 : (DIST_ONE - q_ext);
		end
	end

	// Sequence multiply, root and divide
	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: if (start) state_d = zero_norm ? DS_DONE : DS_MUL;
			DS_MUL:  if (cnt_q == MUL_LAST) state_d = DS_ROOT;
			DS_ROOT: if (cnt_q == ROOT_LAST) state_d = DS_DIV;
			DS_DIV:  if (cnt_q == DIV_LAST) state_d = DS_DONE;
			DS_DONE: state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == DS_DONE);
		distance = dist_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				acc_q <= '0;
				mb_q <= enorm;
				dot_q <= '0;
				dist_q <= DIST_TWO;
			end
			DS_MUL: begin
				acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (mb_q[NORM_W-1] ? PROD_W'(qnorm) : '0);
				mb_q <= {mb_q[NORM_W-2:0], 1'b0};
				if (cnt_q < 6'(VEC_DIM)) begin
					dot_q <= dot_q + DOT_W'(prod);
				end
				rem_q <= '0;
				root_q <= '0;
			end
			DS_ROOT: begin
				// load the dividend after the last root digit
				rem_q <= (cnt_q == ROOT_LAST) ? REM_W'(mag) :
					(root_ge ? (rem_cat - trial) : rem_cat);
				root_q <= {root_q[NORM_W-2:0], root_ge};
				acc_q <= {acc_q[PROD_W-3:0], 2'b00};
				quo_q <= '0;
			end
			DS_DIV: begin
				rem_q <= {div_rem[REM_W-2:0], 1'b0};
				quo_q <= quo_new;
				if (cnt_q == DIV_LAST) begin
					dist_q <= dist_new;
				end
			end
			DS_DONE: begin
				dist_q <= dist_q;
			end
			default: begin
				dist_q <= dist_q;
			end
		endcase
	end

endmodule

// ----- design/cosine_rank_of_target_core.sv -----
// Channel | Signals                          | Transfer when
// req     | req_valid, req_stall, req        | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp        | rsp_valid && !rsp_stall
// cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// A load is accepted, then the squares of its eight components are summed.
// A query sums its own squares the same way (n = entries in play); then the chain
// makes one full rotation to compute and one to rank: the serial distance unit
// works on each of the n entries (skipping the work when a norm is zero), and
// every other cell passes the head straight on.
// Reset clears control state only; index contents stay undefined until loaded.
// A finished result waits in the output register while the next item is taken;
// a later query holds in its final state until that register is free.
module cosine_rank_of_target_core import crt_pkg::*; #(
	parameter int INDEX_DEPTH = CRT_INDEX_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  crt_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output crt_rsp_t             rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IW = $clog2(INDEX_DEPTH);
	localparam int CW = $clog2(INDEX_DEPTH + 1);
	localparam int RW = $clog2(INDEX_DEPTH + 2);
	localparam logic [IW-1:0] IDX_LAST = IW'(INDEX_DEPTH - 1);

	crt_state_t state_q, state_d;
	logic [CFG_W-1:0] entry_count_q, cutoff_first_q, cutoff_second_q, cutoff_third_q;
	crt_req_t item_q;
	logic [NORM_W-1:0] norm_q;
	logic [2:0] comp_q;
	logic [IW-1:0] idx_q, target_q;
	logic [CW-1:0] n_q;
	logic found_q, busy_q;
	logic [DIST_W-1:0] tdist_q;
	logic [RW-1:0] rank_q;
	crt_rsp_t rsp_q;
	logic rsp_valid_q;

	crt_entry_t cell_entry [INDEX_DEPTH];
	crt_cell_ctl_t cell_ctl [INDEX_DEPTH];
	crt_entry_t head, wrap_entry, load_entry;
	crt_vec_t item_vec;
	logic signed [31:0] sq;
	logic [NORM_W-1:0] norm_next;
	logic norm_last, in_range, last, do_shift, do_load, rsp_free;
	logic dist_start, dist_done;
	logic [DIST_W-1:0] dist_res;
	logic [31:0] n_wide, rank_wide;
	logic [RW-1:0] rank_fin;
	logic ranks_before;

	// Serial distance unit on the chain head
	crt_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dist_start),
		.qvec    (item_vec),
		.qnorm   (norm_q),
		.evec    (head.vec),
		.enorm   (head.norm),
		.done    (dist_done),
		.distance(dist_res)
	);

	// Rotating row of index cells
	for (genvar i = 0; i < INDEX_DEPTH; i++) begin : g_cell
		always_comb begin
			cell_ctl[i].shift = do_shift;
			cell_ctl[i].load = do_load && (32'(item_q.slot) == i);
		end
		crt_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[i]),
			.shift_in((i == INDEX_DEPTH - 1) ? wrap_entry : cell_entry[(i + 1) % INDEX_DEPTH]),
			.load_in (load_entry),
			.entry   (cell_entry[i])
		);
	end

	// Shared datapath terms
	always_comb begin
		head = cell_entry[0];
		item_vec = crt_req_vec(item_q);
		sq = $signed(item_vec[comp_q]) * $signed(item_vec[comp_q]);
		norm_next = norm_q + NORM_W'(unsigned'(sq));
		norm_last = (comp_q == 3'd7);
		in_range = CW'(idx_q) < n_q;
		last = (idx_q == IDX_LAST);
		n_wide = (32'(entry_count_q) < INDEX_DEPTH) ? 32'(entry_count_q) : INDEX_DEPTH;
		load_entry.id = item_q.doc_id;
		load_entry.vec = item_vec;
		load_entry.norm = norm_next;
		load_entry.distance = DIST_TWO;
		wrap_entry = head;
		if (state_q == ST_DIST && in_range) begin
			wrap_entry.distance = dist_res;
		end
		ranks_before = (head.distance < tdist_q) ||
			((head.distance == tdist_q) && (idx_q < target_q));
		rank_fin = found_q ? rank_q : (RW'(n_q) + RW'(1));
		rank_wide = 32'(rank_fin);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_NORM;
			ST_NORM: begin
				if (norm_last) begin
					state_d = (item_q.req_type == REQ_QUERY) ? ST_DIST : ST_IDLE;
				end
			end
			ST_DIST: if (do_shift && last) state_d = ST_RANK;
			ST_RANK: if (last) state_d = ST_DONE;
			ST_DONE: if (rsp_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		rsp_free = !rsp_valid_q || !rsp_stall;
		dist_start = (state_q == ST_DIST) && in_range && !busy_q;
		do_shift = ((state_q == ST_DIST) && (!in_range || dist_done)) || (state_q == ST_RANK);
		do_load = (state_q == ST_NORM) && norm_last && (item_q.req_type == REQ_LOAD);
		rsp_valid = rsp_valid_q;
		rsp = rsp_q;
	end

	// Hold the accepted item and register the response
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_q <= req;
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.rank <= (rank_wide > RANK_MAX) ? RANK_W'(RANK_MAX) : rank_wide[RANK_W-1:0];
			rsp_q.hit_first <= rank_wide <= 32'(cutoff_first_q);
			rsp_q.hit_second <= rank_wide <= 32'(cutoff_second_q);
			rsp_q.hit_third <= rank_wide <= 32'(cutoff_third_q);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_count_q <= RST_ENTRY_COUNT;
			cutoff_first_q <= RST_CUTOFF_FIRST;
			cutoff_second_q <= RST_CUTOFF_SECOND;
			cutoff_third_q <= RST_CUTOFF_THIRD;
			norm_q <= '0;
			comp_q <= '0;
			idx_q <= '0;
			target_q <= '0;
			n_q <= '0;
			found_q <= 1'b0;
			busy_q <= 1'b0;
			tdist_q <= '0;
			rank_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_COUNT:   entry_count_q <= cfg_data;
					CFG_CUTOFF_FIRST:  cutoff_first_q <= cfg_data;
					CFG_CUTOFF_SECOND: cutoff_second_q <= cfg_data;
					CFG_CUTOFF_THIRD:  cutoff_third_q <= cfg_data;
					default:           entry_count_q <= entry_count_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					norm_q <= '0;
					comp_q <= '0;
				end
				ST_NORM: begin
					norm_q <= norm_next;
					comp_q <= comp_q + 3'd1;
					idx_q <= '0;
					found_q <= 1'b0;
					busy_q <= 1'b0;
					rank_q <= RW'(1);
					n_q <= CW'(n_wide);
				end
				ST_DIST: begin
					// advance once the head entry has its distance, or at once if it is out of range
					if (dist_start) begin
						busy_q <= 1'b1;
					end
					if (do_shift) begin
						busy_q <= 1'b0;
						idx_q <= last ? '0 : (idx_q + IW'(1));
						if (in_range && !found_q && head.id == item_q.doc_id) begin
							found_q <= 1'b1;
							target_q <= idx_q;
							tdist_q <= dist_res;
						end
					end
				end
				ST_RANK: begin
					// count entries that place ahead of the target
					idx_q <= last ? '0 : (idx_q + IW'(1));
					if (in_range && found_q && ranks_before) begin
						rank_q <= rank_q + RW'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
			// Output register: fill on completion, drop on transfer
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
